### rtl/core/wcp_pkg.sv
// shared types and constants for the wave chunk parser
package wcp_pkg;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_RIFFTYPE = 3'd1;
  localparam logic [2:0] PH_FMT      = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_SKIP     = 3'd4;
  localparam logic [2:0] PH_PAD      = 3'd5;
  localparam logic [2:0] PH_FINISH   = 3'd6;
  localparam logic [2:0] PH_DONE     = 3'd7;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_FORMAT   = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [3:0] ERR_SHORT_HEADER = 4'd0;
  localparam logic [3:0] ERR_SHORT_TYPE   = 4'd1;
  localparam logic [3:0] ERR_NOT_WAVE     = 4'd2;
  localparam logic [3:0] ERR_SHORT_FMT    = 4'd3;
  localparam logic [3:0] ERR_SHORT_DATA   = 4'd4;
  localparam logic [3:0] ERR_NO_RIFF      = 4'd5;
  localparam logic [3:0] ERR_NO_FMT       = 4'd6;
  localparam logic [3:0] ERR_NO_DATA      = 4'd7;
  localparam logic [3:0] ERR_WIDTH        = 4'd8;
  localparam logic [3:0] ERR_ORDER        = 4'd9;

  localparam logic [1:0] SEL_ALL  = 2'd0;
  localparam logic [1:0] SEL_LEFT = 2'd1;

  localparam int TDATA_W = 88;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] byte_index;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    logic        riff_seen;
    logic        fmt_seen;
    logic        data_seen;
    logic [15:0] num_channels;
    logic [15:0] bits_each;
    logic [31:0] rate_value;
    logic [7:0]  pending_low_byte;
    logic        frame_position;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [15:0] channels;
    logic [15:0] sample_bits;
    logic [31:0] rate_hz;
    logic [3:0]  error_code;
  } result_t;

endpackage

### rtl/core/wav_chunk_parser_channel_select.sv
// riff/wave byte stream parser with stereo channel selection, top level
// an accepted input word is registered in the input stage, then its result word in the m_tdata register
// throughput: one byte word per cycle while m_tready does not stall the result register; the parse state
// updates in the same cycle as each registered word moves into the result register
// reset (rst, synchronous): parser back to chunk header, flags and format cleared,
// channel_select 0, both stages empty
module wav_chunk_parser_channel_select_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [wcp_pkg::TDATA_W-1:0] m_tdata, // sample, channels, sample_bits, rate_hz,
                                                // error_code, zero pad
  output logic [1:0]  m_tuser,   // kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import wcp_pkg::*;

  logic [1:0] channel_select;
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;
  logic       advance;
  state_t     parse_state;
  state_t     parse_state_next;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= '0;
    end else if (cfg_valid) begin
      channel_select <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  wcp_step u_step (
    .channel_select (channel_select),
    .action         (in_action),
    .data_byte      (in_byte),
    .cur            (parse_state),
    .nxt            (parse_state_next),
    .res            (res)
  );

  // all-zero state is the header phase
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= '0;
    end else if (advance) begin
      parse_state <= parse_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= res.kind;
      m_tdata <= {4'd0, res.error_code, res.rate_hz, res.sample_bits,
                  res.channels, res.sample};
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    parse_state.phase == PH_DONE |=> parse_state.phase == PH_DONE)
    else $error("parser left the halted phase");

  a_final_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_COMPLETE)
    |-> parse_state.phase == PH_DONE)
    else $error("error or completion word without halt");

  a_finish_seen: assert property (@(posedge clk) disable iff (rst)
    parse_state.phase == PH_FINISH
    |-> parse_state.riff_seen && parse_state.fmt_seen && parse_state.data_seen)
    else $error("finish phase before all chunks seen");

endmodule

### rtl/core/wcp_step.sv
// next-state and result logic for one file word
module wcp_step (
  input  logic [1:0]      channel_select,
  input  logic            action,
  input  logic [7:0]      data_byte,
  input  wcp_pkg::state_t cur,
  output wcp_pkg::state_t nxt,
  output wcp_pkg::result_t res
);
  import wcp_pkg::*;

  logic [31:0] idx_n;
  logic [4:0]  shamt;
  logic [31:0] byte_shifted;
  logic [31:0] tag_ins;
  logic [31:0] len_ins;
  logic        selecting;
  logic        want;
  logic        have;
  logic [15:0] smp;

  function automatic result_t err_res(input logic [3:0] code);
    result_t r;
    r = '0;
    r.valid = 1'b1;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t done_res();
    result_t r;
    r = '0;
    r.valid = 1'b1;
    r.kind = KIND_COMPLETE;
    return r;
  endfunction

  function automatic result_t final_res(input state_t s);
    result_t r;
    if (!s.riff_seen) begin
      r = err_res(ERR_NO_RIFF);
    end else if (!s.fmt_seen) begin
      r = err_res(ERR_NO_FMT);
    end else if (!s.data_seen) begin
      r = err_res(ERR_NO_DATA);
    end else begin
      r = done_res();
    end
    return r;
  endfunction

  assign idx_n = cur.byte_index + 32'd1;
  assign shamt = {cur.byte_index[1:0], 3'b000};
  assign byte_shifted = {24'd0, data_byte} << shamt;
  assign tag_ins = cur.chunk_tag | byte_shifted;
  assign len_ins = cur.chunk_length | byte_shifted;
  assign selecting = (cur.num_channels == 16'd2) && (channel_select != SEL_ALL);
  assign want = (channel_select != SEL_LEFT);

  always_comb begin
    nxt = cur;
    res = '0;
    have = 1'b0;
    smp = '0;
    if (cur.phase == PH_DONE) begin
      nxt = cur;
    end else if (action) begin
      // end of file
      nxt.phase = PH_DONE;
      case (cur.phase)
        PH_HEADER: begin
          res = (cur.byte_index == 32'd0) ? final_res(cur) : err_res(ERR_SHORT_HEADER);
        end
        PH_RIFFTYPE: res = err_res(ERR_SHORT_TYPE);
        PH_FMT: begin
          res = (cur.byte_index < 32'd16) ? err_res(ERR_SHORT_FMT) : final_res(cur);
        end
        PH_DATA:   res = err_res(ERR_SHORT_DATA);
        PH_FINISH: res = done_res();
        default:   res = final_res(cur);
      endcase
    end else begin
      case (cur.phase)
        PH_HEADER: begin
          nxt.byte_index = idx_n;
          if (cur.byte_index < 32'd4) begin
            nxt.chunk_tag = tag_ins;
          end else begin
            nxt.chunk_length = len_ins;
          end
          if (cur.byte_index == 32'd7) begin
            nxt.byte_index = '0;
            if (cur.chunk_tag == TAG_RIFF) begin
              nxt.chunk_tag = '0;
              nxt.phase = PH_RIFFTYPE;
            end else if (cur.chunk_tag == TAG_FMT) begin
              nxt.phase = PH_FMT;
            end else if (cur.chunk_tag == TAG_DATA) begin
              if (!cur.fmt_seen) begin
                nxt.phase = PH_DONE;
                res = err_res(ERR_ORDER);
              end else if (selecting && cur.bits_each != 16'd8
                           && cur.bits_each != 16'd16) begin
                nxt.phase = PH_DONE;
                res = err_res(ERR_WIDTH);
              end else begin
                nxt.frame_position = 1'b0;
                nxt.pending_low_byte = '0;
                if (len_ins == 32'd0) begin
                  nxt.data_seen = 1'b1;
                  if (cur.riff_seen) begin
                    nxt.phase = PH_DONE;
                    res = done_res();
                  end else begin
                    nxt.phase = PH_HEADER;
                    nxt.chunk_tag = '0;
                    nxt.chunk_length = '0;
                  end
                end else begin
                  nxt.phase = PH_DATA;
                end
              end
            end else if (len_ins == 32'd0) begin
              nxt.chunk_tag = '0;
              nxt.chunk_length = '0;
            end else begin
              nxt.phase = PH_SKIP;
            end
          end
        end
        PH_RIFFTYPE: begin
          nxt.chunk_tag = tag_ins;
          nxt.byte_index = idx_n;
          if (cur.byte_index == 32'd3) begin
            if (tag_ins != TAG_WAVE) begin
              nxt.phase = PH_DONE;
              res = err_res(ERR_NOT_WAVE);
            end else begin
              nxt.riff_seen = 1'b1;
              if (cur.fmt_seen && cur.data_seen) begin
                nxt.phase = PH_DONE;
                res = done_res();
              end else begin
                nxt.phase = PH_HEADER;
                nxt.byte_index = '0;
                nxt.chunk_tag = '0;
                nxt.chunk_length = '0;
              end
            end
          end
        end
        PH_FMT: begin
          case (cur.byte_index)
            32'd2:  nxt.num_channels[7:0] = data_byte;
            32'd3:  nxt.num_channels[15:8] = data_byte;
            32'd4:  nxt.rate_value[7:0] = data_byte;
            32'd5:  nxt.rate_value[15:8] = data_byte;
            32'd6:  nxt.rate_value[23:16] = data_byte;
            32'd7:  nxt.rate_value[31:24] = data_byte;
            32'd14: nxt.bits_each[7:0] = data_byte;
            32'd15: nxt.bits_each[15:8] = data_byte;
            default: ;
          endcase
          nxt.byte_index = idx_n;
          if (idx_n == 32'd16) begin
            nxt.fmt_seen = 1'b1;
            res.valid = 1'b1;
            res.kind = KIND_FORMAT;
            res.channels = nxt.num_channels;
            res.sample_bits = nxt.bits_each;
            res.rate_hz = nxt.rate_value;
            if (cur.chunk_length <= 32'd16) begin
              nxt.phase = PH_HEADER;
              nxt.byte_index = '0;
              nxt.chunk_tag = '0;
              nxt.chunk_length = '0;
            end
          end else if (idx_n > 32'd16 && idx_n == cur.chunk_length) begin
            if (cur.chunk_length[0]) begin
              nxt.phase = PH_PAD;
            end else begin
              nxt.phase = PH_HEADER;
              nxt.byte_index = '0;
              nxt.chunk_tag = '0;
              nxt.chunk_length = '0;
            end
          end
        end
        PH_DATA: begin
          if (cur.bits_each == 16'd8) begin
            smp = {8'd0, data_byte};
            have = 1'b1;
          end else if (!cur.byte_index[0]) begin
            nxt.pending_low_byte = data_byte;
          end else begin
            smp = {data_byte, cur.pending_low_byte};
            have = 1'b1;
          end
          if (have) begin
            nxt.frame_position = ~cur.frame_position;
            if (!selecting || cur.frame_position == want) begin
              res.valid = 1'b1;
              res.kind = KIND_SAMPLE;
              res.sample = smp;
            end
          end
          nxt.byte_index = idx_n;
          if (idx_n == cur.chunk_length) begin
            nxt.data_seen = 1'b1;
            if (cur.riff_seen && cur.fmt_seen) begin
              // completion goes out with the next word when a sample is out now
              if (res.valid) begin
                nxt.phase = PH_FINISH;
              end else begin
                nxt.phase = PH_DONE;
                res = done_res();
              end
            end else if (cur.chunk_length[0]) begin
              nxt.phase = PH_PAD;
            end else begin
              nxt.phase = PH_HEADER;
              nxt.byte_index = '0;
              nxt.chunk_tag = '0;
              nxt.chunk_length = '0;
            end
          end
        end
        PH_SKIP: begin
          nxt.byte_index = idx_n;
          if (idx_n == cur.chunk_length) begin
            if (cur.chunk_length[0]) begin
              nxt.phase = PH_PAD;
            end else begin
              nxt.phase = PH_HEADER;
              nxt.byte_index = '0;
              nxt.chunk_tag = '0;
              nxt.chunk_length = '0;
            end
          end
        end
        PH_PAD: begin
          nxt.phase = PH_HEADER;
          nxt.byte_index = '0;
          nxt.chunk_tag = '0;
          nxt.chunk_length = '0;
        end
        default: begin
          nxt.phase = PH_DONE;
          res = done_res();
        end
      endcase
    end
  end

endmodule
